// ===== rtl/afs_pkg.sv =====
// shared widths, register indexes and play mode codes for the animation frame selector
package afs_pkg;

    localparam int MAX_FRAMES_DEF   = 256;
    localparam int ELAPSED_BITS_DEF = 32;

    localparam int MODE_W     = 3;
    localparam int INTERVAL_W = 16;
    localparam int COUNT_W    = 9;
    localparam int TICKS_W    = 16;
    localparam int FRAME_W    = 8;
    localparam int MOD_W      = COUNT_W + 1;
    localparam int DUR_W      = COUNT_W + INTERVAL_W;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_PLAY_MODE      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SEQ_LEN        = 2'd2;

    localparam logic [MODE_W-1:0] MODE_NONE         = 3'd0;
    localparam logic [MODE_W-1:0] MODE_NORMAL       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REVERSE      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LOOP         = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOP_REVERSE = 3'd4;
    localparam logic [MODE_W-1:0] MODE_PING_PONG    = 3'd5;

    localparam logic ACTION_ADVANCE = 1'b0;
    localparam logic ACTION_RESTART = 1'b1;

endpackage

// ===== rtl/animation_frame_selector.sv =====
// top level of the animation frame selector: sequencer, time accumulator and output register
//
// Keeps a wrapping ELAPSED_BITS-bit elapsed-time count and, for each item, gives the frame
// index to show and a finished flag (elapsed above the frame count times the frame interval).
// One item is worked on at a time; the result waits in an output register, so the next item
// can be taken while it is still stalled. The sequencer runs the bit-serial divider once for
// elapsed / frame_interval and, in loop, loop reverse and ping-pong modes, once more for the
// wrap modulus; normal and reverse modes use the first division only, and the divider is
// skipped when the mode is none (or an unused code) or only one frame is configured. A
// finished result that finds the output register still stalled holds the sequencer until
// that register is taken. Configuration is written through cfg_we / cfg_index / cfg_data;
// the user must write it only while no item is in flight, and the block itself does not
// enforce this. Indexes past the register list are ignored.
module animation_frame_selector #(
    parameter int MAX_FRAMES   = afs_pkg::MAX_FRAMES_DEF,
    parameter int ELAPSED_BITS = afs_pkg::ELAPSED_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [afs_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [afs_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             action,
    input  logic [afs_pkg::TICKS_W-1:0]      ticks,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [afs_pkg::FRAME_W-1:0]      frame_index,
    output logic                             finished
);

    import afs_pkg::*;

    localparam int N        = ELAPSED_BITS;
    localparam int CmpW     = (ELAPSED_BITS > DUR_W) ? ELAPSED_BITS : DUR_W;
    localparam int CountCap = (MAX_FRAMES < 511) ? MAX_FRAMES : 511;

    typedef enum logic [2:0] {
        S_IDLE,
        S_Q_LOAD,
        S_Q_RUN,
        S_M_LOAD,
        S_M_RUN,
        S_DONE
    } state_t;

    // configuration
    logic [MODE_W-1:0]     play_mode_reg;
    logic [INTERVAL_W-1:0] frame_interval_reg;
    logic [COUNT_W-1:0]    seq_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_mode_reg      <= MODE_NONE;
            frame_interval_reg <= INTERVAL_W'(1);
            seq_len_reg        <= COUNT_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PLAY_MODE:      play_mode_reg      <= cfg_data[MODE_W-1:0];
                REG_FRAME_INTERVAL: frame_interval_reg <= cfg_data[INTERVAL_W-1:0];
                REG_SEQ_LEN:        seq_len_reg        <= cfg_data[COUNT_W-1:0];
                default:            ;
            endcase
        end
    end

    // effective interval and frame count
    logic [INTERVAL_W-1:0] interval;
    logic [COUNT_W-1:0]    count_nz;
    logic [COUNT_W-1:0]    count;
    logic [COUNT_W-1:0]    last;
    logic                  multi;
    logic [MOD_W-1:0]      twice_less2;
    logic [MOD_W-1:0]      modulus;

    assign interval    = (frame_interval_reg == '0) ? INTERVAL_W'(1) : frame_interval_reg;
    assign count_nz    = (seq_len_reg == '0) ? COUNT_W'(1) : seq_len_reg;
    assign count       = (count_nz > COUNT_W'(CountCap)) ? COUNT_W'(CountCap) : count_nz;
    assign last        = count - 1'b1;
    assign multi       = (count > COUNT_W'(1));
    assign twice_less2 = {count, 1'b0} - MOD_W'(2);
    assign modulus     = (play_mode_reg == MODE_PING_PONG) ? twice_less2 : {1'b0, count};

    // sequencer and datapath registers
    state_t              state_reg, state_next;
    logic [N-1:0]        elapsed_reg, elapsed_next;
    logic [CmpW-1:0]     duration_reg, duration_next;
    logic [N-1:0]        q_reg, q_next;
    logic [MOD_W-1:0]    r_reg, r_next;
    logic                out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]  frame_index_reg, frame_index_next;
    logic                finished_reg, finished_next;

    logic                in_take;
    logic                div_start;
    logic [N-1:0]        div_dividend;
    logic [INTERVAL_W-1:0] div_divisor;
    logic                div_done;
    logic [N-1:0]        div_quotient;
    logic [INTERVAL_W-1:0] div_remainder;

    logic                mode_divides;
    logic                mode_wraps;
    logic [FRAME_W-1:0]  pick;
    logic [COUNT_W-1:0]  rev_pick;
    logic [COUNT_W-1:0]  loop_rev_pick;
    logic [MOD_W-1:0]    pong_pick;

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign div_start = (state_reg == S_Q_LOAD) || (state_reg == S_M_LOAD);
    assign div_dividend = (state_reg == S_Q_LOAD) ? elapsed_reg : q_reg;
    assign div_divisor  = (state_reg == S_Q_LOAD) ? interval : INTERVAL_W'(modulus);

    always_comb
    begin
        mode_divides = 1'b0;
        mode_wraps   = 1'b0;
        case (play_mode_reg) inside
            MODE_NORMAL, MODE_REVERSE:
                mode_divides = 1'b1;
            MODE_LOOP, MODE_LOOP_REVERSE, MODE_PING_PONG:
            begin
                mode_divides = 1'b1;
                mode_wraps   = 1'b1;
            end
            default:
                ;
        endcase
    end

    // frame choice from the quotient and the wrapped remainder
    assign rev_pick      = last - q_reg[COUNT_W-1:0];
    assign loop_rev_pick = last - r_reg[COUNT_W-1:0];
    assign pong_pick     = (r_reg >= {1'b0, count}) ? (twice_less2 - r_reg) : r_reg;

    always_comb
    begin
        pick = '0;
        if (multi)
        begin
            unique case (play_mode_reg)
                MODE_NORMAL:
                    pick = (q_reg < N'(last)) ? q_reg[FRAME_W-1:0] : last[FRAME_W-1:0];
                MODE_REVERSE:
                    pick = (q_reg >= N'(last)) ? '0 : rev_pick[FRAME_W-1:0];
                MODE_LOOP:
                    pick = r_reg[FRAME_W-1:0];
                MODE_LOOP_REVERSE:
                    pick = loop_rev_pick[FRAME_W-1:0];
                MODE_PING_PONG:
                    pick = pong_pick[FRAME_W-1:0];
                default:
                    pick = '0;
            endcase
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        elapsed_next     = elapsed_reg;
        duration_next    = duration_reg;
        q_next           = q_reg;
        r_next           = r_reg;
        frame_index_next = frame_index_reg;
        finished_next    = finished_reg;
        out_valid_next   = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    if (action == ACTION_RESTART)
                        elapsed_next = '0;
                    else if (multi)
                        elapsed_next = elapsed_reg + N'(ticks);
                    duration_next = CmpW'(DUR_W'(count) * DUR_W'(interval));
                    q_next        = '0;
                    r_next        = '0;
                    state_next    = (multi && mode_divides) ? S_Q_LOAD : S_DONE;
                end
            end
            S_Q_LOAD:
                state_next = S_Q_RUN;
            S_Q_RUN:
            begin
                if (div_done)
                begin
                    q_next     = div_quotient;
                    state_next = mode_wraps ? S_M_LOAD : S_DONE;
                end
            end
            S_M_LOAD:
                state_next = S_M_RUN;
            S_M_RUN:
            begin
                if (div_done)
                begin
                    r_next     = div_remainder[MOD_W-1:0];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                // the result moves on once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    frame_index_next = pick;
                    finished_next    = (CmpW'(elapsed_reg) > duration_reg);
                    state_next       = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
            duration_reg    <= '0;
            q_reg           <= '0;
            r_reg           <= '0;
            frame_index_reg <= '0;
            finished_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            elapsed_reg     <= elapsed_next;
            out_valid_reg   <= out_valid_next;
            duration_reg    <= duration_next;
            q_reg           <= q_next;
            r_reg           <= r_next;
            frame_index_reg <= frame_index_next;
            finished_reg    <= finished_next;
        end
    end

    afs_serial_div #(
        .N (N),
        .D (INTERVAL_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign out_valid   = out_valid_reg;
    assign frame_index = frame_index_reg;
    assign finished    = finished_reg;

endmodule

// ===== rtl/afs_serial_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
module afs_serial_div #(
    parameter int N = afs_pkg::ELAPSED_BITS_DEF,
    parameter int D = afs_pkg::INTERVAL_W
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         done,
    output logic [N-1:0] quotient,
    output logic [D-1:0] remainder
);

    localparam int CntW = $clog2(N + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic [N-1:0]    quo_reg, quo_next;
    logic [D-1:0]    rem_reg, rem_next;
    logic [D-1:0]    den_reg, den_next;

    logic [D:0]      trial;
    logic [D+1:0]    diff;
    logic            fits;

    // shift the next dividend bit into the partial remainder and try the subtract
    assign trial = {rem_reg, quo_reg[N-1]};
    assign diff  = {1'b0, trial} - {2'b00, den_reg};
    assign fits  = ~diff[D+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CntW'(N);
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[N-2:0], fits};
            rem_next = fits ? diff[D-1:0] : trial[D-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/afs_checker.sv =====
// port-level checks for the animation frame selector and the bind that attaches them
module afs_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [afs_pkg::FRAME_W-1:0]      frame_index,
    input  logic                             finished
);

    logic       in_take;
    logic       out_take;
    logic [1:0] pending_reg, pending_next;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // items taken in whose results have not yet gone out
    always_comb
    begin
        pending_next = pending_reg;
        if (in_take && !out_take)
            pending_next = pending_reg + 1'b1;
        else if (!in_take && out_take)
            pending_next = pending_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(frame_index) && $stable(finished))
        else $error("stalled result changed or was dropped");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_stall)
        else $error("input not stalled while an item is being worked on");

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != 2'd0)
        else $error("result shown with no item outstanding");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> pending_reg == 2'd0 || pending_reg == 2'd1)
        else $error("input open while two items are outstanding");

endmodule

bind animation_frame_selector afs_checker u_afs_checker (.*);

// ===== dv/afs_frame_checker.sv =====
// frame checker for the animation frame selector: follows configuration, predicts and compares results
module afs_frame_checker
    import afs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   action,
    input  logic [TICKS_W-1:0]     ticks,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [FRAME_W-1:0]     frame_index,
    input  logic                   finished,
    output int                     failures,
    output int                     outstanding
);

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               finished;
    } frame_result_t;

    logic [MODE_W-1:0]           mode_q;
    logic [INTERVAL_W-1:0]       interval_q;
    logic [COUNT_W-1:0]          count_q;
    logic [ELAPSED_BITS_DEF-1:0] elapsed_q;
    frame_result_t               frames_due[$];
    int                          mismatch_total = 0;

    function automatic int unsigned frames_in_use(logic [COUNT_W-1:0] c);
        if (c == 0)
            return 1;
        if (c > MAX_FRAMES_DEF)
            return MAX_FRAMES_DEF;
        return c;
    endfunction

    // frame to show and finished flag for a given elapsed time
    function automatic frame_result_t frame_at(logic [ELAPSED_BITS_DEF-1:0] t,
                                               logic [MODE_W-1:0] m,
                                               int unsigned ivl, int unsigned cnt);
        int unsigned q;
        int unsigned last;
        int unsigned f;
        frame_result_t r;
        q = t / ivl;
        last = cnt - 1;
        f = 0;
        if (cnt > 1)
        begin
            case (m)
                MODE_NORMAL:       f = (q < last) ? q : last;
                MODE_REVERSE:      f = (q >= last) ? 0 : last - q;
                MODE_LOOP:         f = q % cnt;
                MODE_LOOP_REVERSE: f = last - (q % cnt);
                MODE_PING_PONG:
                begin
                    f = q % (2 * cnt - 2);
                    // second half of the swing runs back down towards frame 1
                    if (f >= cnt)
                        f = (cnt - 2) - (f - cnt);
                end
                default:           f = 0;
            endcase
        end
        r.frame = f[FRAME_W-1:0];
        r.finished = (t > cnt * ivl);
        return r;
    endfunction

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatch_total++;
        $error("%s: expected %0d, got %0d", field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t got;
        frame_result_t want;
        int unsigned cnt;
        int unsigned ivl;
        if (!rst_n)
        begin
            mode_q = MODE_NONE;
            interval_q = 1;
            count_q = 1;
            elapsed_q = '0;
            frames_due.delete();
            outstanding <= 0;
            failures <= mismatch_total;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PLAY_MODE:      mode_q = cfg_data[MODE_W-1:0];
                    REG_FRAME_INTERVAL: interval_q = cfg_data[INTERVAL_W-1:0];
                    REG_SEQ_LEN:        count_q = cfg_data[COUNT_W-1:0];
                    default:            ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                cnt = frames_in_use(count_q);
                ivl = (interval_q == 0) ? 1 : interval_q;
                if (action == ACTION_RESTART)
                    elapsed_q = '0;
                else if (cnt > 1)
                    elapsed_q = elapsed_q + ticks;
                frames_due.push_back(frame_at(elapsed_q, mode_q, ivl, cnt));
            end
            if (out_valid && !out_stall)
            begin
                got.frame = frame_index;
                got.finished = finished;
                if (frames_due.size() == 0)
                begin
                    mismatch_total++;
                    $error("frame result with no item outstanding: frame_index %0d finished %0d",
                           got.frame, got.finished);
                end
                else
                begin
                    want = frames_due.pop_front();
                    if (got.frame !== want.frame)
                        note_mismatch("frame_index", 32'(want.frame), 32'(got.frame));
                    if (got.finished !== want.finished)
                        note_mismatch("finished", 32'(want.finished), 32'(got.finished));
                end
            end
            outstanding <= frames_due.size();
            failures <= mismatch_total;
        end
    end

endmodule

// ===== dv/tb_animation_frame_selector.sv =====
// testbench top for the animation frame selector: stimulus, register writes and verdict
module tb_animation_frame_selector;
    import afs_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 1550;
    localparam int BULK_ITEMS   = 48;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 4000000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic                   action;
    logic [TICKS_W-1:0]     ticks;
    logic                   out_valid;
    logic                   out_stall;
    logic [FRAME_W-1:0]     frame_index;
    logic                   finished;

    int          failures;
    int          outstanding;
    int unsigned cycle_count = 0;
    bit          steady;
    int unsigned ivl_now;
    int          random_items;

    animation_frame_selector uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .ticks       (ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_index (frame_index),
        .finished    (finished)
    );

    afs_frame_checker frame_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .ticks       (ticks),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .frame_index (frame_index),
        .finished    (finished),
        .failures    (failures),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[animation_frame_selector] ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_cycles();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side back-pressure: alternating free and stalled runs
    initial
    begin
        int unsigned run;
        bit stalling;
        run = 0;
        stalling = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (run == 0)
            begin
                stalling = !stalling && !steady;
                run = stalling ? gap_cycles() + 1 : $urandom_range(1, 8);
            end
            run--;
            out_stall <= stalling;
        end
    end

    task automatic send_item(logic act, logic [TICKS_W-1:0] t);
        int unsigned gap;
        gap = gap_cycles();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        ticks <= t;
        do @(posedge clk); while (in_stall);
    endtask

    // registers only change once every result has come back
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_FRAME_INTERVAL)
            ivl_now = (data == '0) ? 1 : 32'(data);
    endtask

    initial
    begin
        int unsigned r;
        int unsigned picked;
        int unsigned phase_items;
        logic [CFG_DATA_W-1:0] data;
        logic [TICKS_W-1:0] t;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_PLAY_MODE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        action <= ACTION_ADVANCE;
        ticks <= '0;
        steady = 1'b0;
        ivl_now = 1;
        random_items = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // single frame straight after reset: elapsed must not move
        send_item(ACTION_ADVANCE, 16'hFFFF);

        // zero interval behaves as one, normal mode clamps at the last frame
        write_reg(REG_SEQ_LEN, 16'd4);
        write_reg(REG_FRAME_INTERVAL, 16'd0);
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_NORMAL));
        send_item(ACTION_ADVANCE, 16'd0);
        send_item(ACTION_ADVANCE, 16'd2);
        send_item(ACTION_ADVANCE, 16'd1);
        send_item(ACTION_ADVANCE, 16'hFFFF);
        send_item(ACTION_RESTART, 16'hFFFF);

        // reverse runs down and holds at frame 0
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_REVERSE));
        send_item(ACTION_RESTART, 16'd0);
        send_item(ACTION_ADVANCE, 16'd1);
        send_item(ACTION_ADVANCE, 16'd5);

        // back to one frame: elapsed held, finished still taken from it
        write_reg(REG_SEQ_LEN, 16'd1);
        send_item(ACTION_ADVANCE, 16'd100);

        // oversized count is cut to the frame limit
        write_reg(REG_SEQ_LEN, 16'd300);
        write_reg(REG_FRAME_INTERVAL, 16'd1);
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_NORMAL));
        send_item(ACTION_RESTART, 16'd0);
        send_item(ACTION_ADVANCE, 16'd280);

        // unused mode codes show frame 0
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_SPARE_LO));
        send_item(ACTION_ADVANCE, 16'd7);
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_SPARE_HI));
        send_item(ACTION_ADVANCE, 16'd1);

        write_reg(REG_SEQ_LEN, 16'd511);
        write_reg(REG_FRAME_INTERVAL, 16'hFFFF);
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_LOOP_REVERSE));
        send_item(ACTION_RESTART, 16'd0);
        send_item(ACTION_ADVANCE, 16'hFFFF);

        // zero count and zero interval together
        write_reg(REG_SEQ_LEN, 16'd0);
        write_reg(REG_FRAME_INTERVAL, 16'd0);
        send_item(ACTION_ADVANCE, 16'd9);

        // shortest ping-pong swing
        write_reg(REG_SEQ_LEN, 16'd2);
        write_reg(REG_FRAME_INTERVAL, 16'd1);
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_PING_PONG));
        send_item(ACTION_RESTART, 16'd0);
        send_item(ACTION_ADVANCE, 16'd1);
        send_item(ACTION_ADVANCE, 16'd1);
        send_item(ACTION_ADVANCE, 16'd1);
        write_reg(REG_SEQ_LEN, 16'd5);
        write_reg(REG_FRAME_INTERVAL, 16'd2);
        send_item(ACTION_ADVANCE, 16'd10);

        // write to the unused index must change nothing
        write_reg(REG_SPARE, 16'hFFFF);
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_LOOP));
        send_item(ACTION_ADVANCE, 16'd3);
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_NONE));
        send_item(ACTION_ADVANCE, 16'd4);

        // a run of large advances with the cheap mode, then the dividing modes on top of it
        steady = 1'b1;
        write_reg(REG_SEQ_LEN, 16'd2);
        write_reg(REG_FRAME_INTERVAL, 16'd1);
        send_item(ACTION_RESTART, 16'd0);
        repeat (BULK_ITEMS) send_item(ACTION_ADVANCE, 16'hFFFF);
        write_reg(REG_SEQ_LEN, CFG_DATA_W'($urandom_range(2, 256)));
        write_reg(REG_FRAME_INTERVAL, CFG_DATA_W'($urandom_range(1, 65535)));
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_PING_PONG));
        repeat (4) send_item(ACTION_ADVANCE, 16'hFFFF);
        write_reg(REG_PLAY_MODE, CFG_DATA_W'(MODE_LOOP));
        repeat (2) send_item(ACTION_ADVANCE, 16'hFFFF);
        steady = 1'b0;

        while (random_items < RANDOM_ITEMS)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) != 0)
            begin
                r = $urandom_range(0, 15);
                picked = (r < 14) ? r % 6 : r - 8;
                data = CFG_DATA_W'($urandom);
                data[MODE_W-1:0] = MODE_W'(picked);
                write_reg(REG_PLAY_MODE, data);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       data = 16'd0;
                    1:       data = 16'd1;
                    2:       data = 16'hFFFF;
                    3, 4, 5: data = CFG_DATA_W'($urandom_range(1, 8));
                    6, 7:    data = CFG_DATA_W'($urandom_range(9, 400));
                    default: data = CFG_DATA_W'($urandom);
                endcase
                write_reg(REG_FRAME_INTERVAL, data);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                case ($urandom_range(0, 9))
                    0:       picked = 0;
                    1:       picked = 1;
                    2:       picked = 2;
                    3:       picked = 256;
                    4:       picked = $urandom_range(257, 511);
                    5, 6, 7: picked = $urandom_range(3, 12);
                    default: picked = $urandom_range(2, 256);
                endcase
                data = CFG_DATA_W'($urandom);
                data[COUNT_W-1:0] = COUNT_W'(picked);
                write_reg(REG_SEQ_LEN, data);
            end
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_SPARE, CFG_DATA_W'($urandom));
            phase_items = $urandom_range(10, 80);
            repeat (phase_items)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    send_item(ACTION_RESTART, TICKS_W'($urandom));
                else
                begin
                    // ticks mostly around one interval so the frames step through the sequence
                    if (r < 10)
                        t = '0;
                    else if (r < 14)
                        t = 16'hFFFF;
                    else if (r < 24 || ivl_now > 32767)
                        t = TICKS_W'($urandom);
                    else
                        t = TICKS_W'($urandom_range(0, 2 * ivl_now));
                    send_item(ACTION_ADVANCE, t);
                end
                random_items++;
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("[animation_frame_selector] OK");
        else
            $display("[animation_frame_selector] ERROR");
        $finish;
    end

endmodule
